>>> design/dtnp_pkg.sv
package dtnp_pkg;

  localparam int MAX_DIGITS_DEF    = 18;
  localparam int FRACTION_BITS_DEF = 16;
  localparam int EXP_LIMIT_DEF     = 99;

  localparam logic [63:0] LIM_POS = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] LIM_NEG = 64'h8000_0000_0000_0000;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_BAD   = 2'd2;
  localparam logic [1:0] ST_SAT   = 2'd3;

  typedef enum logic [2:0] {
    PH_SIGN  = 3'd0,
    PH_INT   = 3'd1,
    PH_FRAC  = 3'd2,
    PH_E     = 3'd3,
    PH_ESIGN = 3'd4,
    PH_EDIG  = 3'd5
  } phase_t;

  typedef enum logic [1:0] {
    SC_IDLE,
    SC_UP,
    SC_DOWN,
    SC_DONE
  } scale_state_t;

  // finished text handed from the front to the back
  typedef struct packed {
    logic        negative;
    logic [63:0] significand;
    logic [10:0] exp_total;
    logic        do_scale;
    logic [1:0]  status;
    logic [63:0] magnitude;
  } job_t;

endpackage

>>> design/dtnp_if.sv
interface dtnp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       last_char;
  modport source (output valid, char_code, last_char, input ready);
  modport sink   (input valid, char_code, last_char, output ready);
endinterface

interface dtnp_out_if;
  logic               valid;
  logic               ready;
  logic signed [63:0] value;
  logic [1:0]         status;
  modport source (output valid, value, status, input ready);
  modport sink   (input valid, value, status, output ready);
endinterface

>>> design/dtnp_front.sv
module dtnp_front
  import dtnp_pkg::*;
#(
  parameter int MAX_DIGITS = MAX_DIGITS_DEF,
  parameter int EXP_LIMIT  = EXP_LIMIT_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         number_kind,
  dtnp_in_if.sink      in_ch,
  output logic         job_valid,
  output job_t         job,
  input  logic         job_ready
);

  phase_t      parse_phase, parse_phase_next;
  logic        negative, negative_next;
  logic [63:0] significand, significand_next;
  logic [4:0]  kept_digits, kept_digits_next;
  logic signed [9:0] decimal_shift, decimal_shift_next;
  logic        exponent_negative, exponent_negative_next;
  logic [9:0]  exponent_value, exponent_value_next;
  logic        seen_any, seen_any_next;
  logic [1:0]  error_code, error_code_next;
  logic        ended_early, ended_early_next;

  logic [7:0]  c;
  logic        digit, is_e, is_sign, is_point;
  logic [3:0]  d;
  logic        accept;
  phase_t      ph;
  logic [63:0] lim, sig10;
  logic [67:0] sig_grow;
  logic [13:0] ev;
  logic signed [11:0] ex;
  logic [1:0]  status;
  logic [63:0] mag;
  logic        scale;

  assign in_ch.ready = job_ready;
  assign accept = in_ch.valid & in_ch.ready;
  assign c = in_ch.char_code;
  assign digit = (c >= 8'd48) && (c <= 8'd57);
  assign d = c[3:0];
  assign is_e = (c == 8'h65) || (c == 8'h45);
  assign is_sign = (c == 8'h2B) || (c == 8'h2D);
  assign is_point = (c == 8'h2E) || (c == 8'h2C);
  assign sig10 = significand * 64'd10;
  assign sig_grow = {4'd0, significand} * 68'd10 + {64'd0, d};

  function automatic logic signed [9:0] sat_shift(input logic signed [9:0] s,
                                                  input logic up);
    logic signed [10:0] t;
    begin
      t = up ? 11'(s) + 11'sd1 : 11'(s) - 11'sd1;
      if (t > 11'sd511) t = 11'sd511;
      if (t < -11'sd512) t = -11'sd512;
      sat_shift = t[9:0];
    end
  endfunction

  always_comb begin
    parse_phase_next = parse_phase;
    negative_next = negative;
    significand_next = significand;
    kept_digits_next = kept_digits;
    decimal_shift_next = decimal_shift;
    exponent_negative_next = exponent_negative;
    exponent_value_next = exponent_value;
    seen_any_next = seen_any;
    error_code_next = error_code;
    ended_early_next = ended_early;
    ph = parse_phase;
    lim = (negative ? LIM_NEG : LIM_POS);
    ev = 14'(exponent_value) * 14'd10 + 14'(d);
    if (!ended_early && error_code != ST_BAD) begin
      if (c == 8'd0) begin
        ended_early_next = 1'b1;
      end else begin
        if (parse_phase == PH_SIGN) begin
          ph = PH_INT;
          parse_phase_next = PH_INT;
          if (is_sign) begin
            negative_next = (c == 8'h2D);
          end
        end
        if (!(parse_phase == PH_SIGN && is_sign)) begin
          if (!number_kind) begin
            if (ph != PH_INT || !digit) begin
              error_code_next = ST_BAD;
            end else begin
              seen_any_next = 1'b1;
              if (sig_grow > {4'd0, lim}) begin
                significand_next = lim;
                error_code_next = ST_SAT;
              end else begin
                significand_next = sig10 + 64'(d);
              end
            end
          end else begin
            case (ph)
              PH_INT, PH_FRAC: begin
                if (digit) begin
                  seen_any_next = 1'b1;
                  if (significand == 64'd0 && d == 4'd0) begin
                    if (ph == PH_FRAC) decimal_shift_next = sat_shift(decimal_shift, 1'b0);
                  end else if (32'(kept_digits) < MAX_DIGITS &&
                               significand <= 64'h1999_9999_9999_9998) begin
                    significand_next = sig10 + 64'(d);
                    kept_digits_next = kept_digits + 5'd1;
                    if (ph == PH_FRAC) decimal_shift_next = sat_shift(decimal_shift, 1'b0);
                  end else if (ph == PH_INT) begin
                    decimal_shift_next = sat_shift(decimal_shift, 1'b1);
                  end
                end else if (ph == PH_INT && is_point) begin
                  parse_phase_next = PH_FRAC;
                end else if (is_e && seen_any) begin
                  parse_phase_next = PH_E;
                end else begin
                  error_code_next = ST_BAD;
                end
              end
              PH_E: begin
                if (is_sign) begin
                  exponent_negative_next = (c == 8'h2D);
                  parse_phase_next = PH_ESIGN;
                end else if (digit) begin
                  exponent_value_next = (ev > 14'(EXP_LIMIT)) ? 10'(EXP_LIMIT) : ev[9:0];
                  parse_phase_next = PH_EDIG;
                end else begin
                  error_code_next = ST_BAD;
                end
              end
              PH_ESIGN, PH_EDIG: begin
                if (digit) begin
                  exponent_value_next = (ev > 14'(EXP_LIMIT)) ? 10'(EXP_LIMIT) : ev[9:0];
                  parse_phase_next = PH_EDIG;
                end else begin
                  error_code_next = ST_BAD;
                end
              end
              default: error_code_next = ST_BAD;
            endcase
          end
        end
      end
    end
  end

  // finish from the updated state
  always_comb begin
    status = ST_OK;
    mag = 64'd0;
    scale = 1'b0;
    ex = 12'(decimal_shift_next) + (exponent_negative_next ?
         -12'(exponent_value_next) : 12'(exponent_value_next));
    if (error_code_next == ST_BAD) status = ST_BAD;
    else if (parse_phase_next == PH_SIGN) status = ST_EMPTY;
    else if (!seen_any_next) status = ST_BAD;
    else if (!number_kind) begin
      if (parse_phase_next != PH_INT) status = ST_BAD;
      else begin
        mag = significand_next;
        status = (error_code_next == ST_SAT) ? ST_SAT : ST_OK;
      end
    end else if (parse_phase_next == PH_E || parse_phase_next == PH_ESIGN) begin
      status = ST_BAD;
    end else begin
      scale = 1'b1;
      status = (error_code_next == ST_SAT) ? ST_SAT : ST_OK;
    end
  end

  assign job_valid = accept & in_ch.last_char;
  assign job.negative = negative_next;
  assign job.significand = significand_next;
  assign job.exp_total = ex[10:0];
  assign job.do_scale = scale;
  assign job.status = status;
  assign job.magnitude = mag;

  always_ff @(posedge clk) begin
    if (rst || (accept && in_ch.last_char)) begin
      parse_phase <= PH_SIGN;
      negative <= 1'b0;
      significand <= 64'd0;
      kept_digits <= 5'd0;
      decimal_shift <= 10'sd0;
      exponent_negative <= 1'b0;
      exponent_value <= 10'd0;
      seen_any <= 1'b0;
      error_code <= ST_OK;
      ended_early <= 1'b0;
    end else if (accept) begin
      parse_phase <= parse_phase_next;
      negative <= negative_next;
      significand <= significand_next;
      kept_digits <= kept_digits_next;
      decimal_shift <= decimal_shift_next;
      exponent_negative <= exponent_negative_next;
      exponent_value <= exponent_value_next;
      seen_any <= seen_any_next;
      error_code <= error_code_next;
      ended_early <= ended_early_next;
    end
  end

endmodule

>>> design/dtnp_queue.sv
module dtnp_queue
  import dtnp_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  input  job_t in_job,
  output logic in_ready,
  output logic out_valid,
  output job_t out_job,
  input  logic out_ready
);

  job_t       mem [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;

  assign in_ready = (count != 2'd2);
  assign out_valid = (count != 2'd0);
  assign out_job = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) mem[wr_ptr] <= in_job;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (in_valid && in_ready) wr_ptr <= ~wr_ptr;
      if (out_valid && out_ready) rd_ptr <= ~rd_ptr;
      count <= count + 2'(in_valid && in_ready) - 2'(out_valid && out_ready);
    end
  end

endmodule

>>> design/dtnp_back.sv
module dtnp_back
  import dtnp_pkg::*;
#(
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      job_valid,
  input  job_t      job,
  output logic      job_ready,
  dtnp_out_if.source out_ch
);

  localparam logic [31:0] RECIP10    = 32'hCCCC_CCCD;
  localparam logic [31:0] WORD_TENTH = 32'd429496729;

  scale_state_t state, state_next;
  logic [127:0] x;
  logic [63:0]  lim;
  logic [10:0]  steps;
  logic         neg;
  logic [1:0]   status;
  logic         over;
  logic [127:0] x_mul;
  logic [63:0]  mag_out;
  logic [1:0]   st_out;
  logic         take;
  logic signed [10:0] e_in;
  logic [1:0]   div_chunk;
  logic [3:0]   div_rem;
  logic [31:0]  d_word;
  logic [32:0]  d_u;
  logic [64:0]  d_prod;
  logic [29:0]  d_qu;
  logic [31:0]  d_q;
  logic [32:0]  d_back;
  logic         down_idle;
  logic         load_direct;
  logic         load_scaled;

  assign over = (x[127:64] != 64'd0) || (x[63:0] > lim);
  assign x_mul = (x << 3) + (x << 1);
  assign take = job_valid && job_ready;
  assign e_in = job.exp_total;

  // divide by ten one 32-bit word per cycle, high word first
  assign d_word = x[{div_chunk, 5'd0} +: 32];
  assign d_u = {1'b0, d_word} + {29'd0, div_rem} * 33'd6;
  assign d_prod = {32'd0, d_u} * {33'd0, RECIP10};
  assign d_qu = d_prod[64:35];
  assign d_q = {28'd0, div_rem} * WORD_TENTH + {2'd0, d_qu};
  assign d_back = d_u - {3'd0, d_qu} * 33'd10;
  assign down_idle = (div_chunk == 2'd3) && (x == 128'd0);

  always_comb begin
    state_next = state;
    job_ready = 1'b0;
    case (state)
      SC_IDLE: begin
        job_ready = !out_ch.valid || out_ch.ready;
        if (job_valid && job_ready && job.do_scale && job.significand != 64'd0) begin
          if (e_in > 0) state_next = SC_UP;
          else if (e_in < 0) state_next = SC_DOWN;
          else state_next = SC_DONE;
        end
      end
      SC_UP: if (steps == 11'd0 || over) state_next = SC_DONE;
      SC_DOWN: if (down_idle || (div_chunk == 2'd0 && steps == 11'd0)) state_next = SC_DONE;
      SC_DONE: if (!out_ch.valid || out_ch.ready) state_next = SC_IDLE;
      default: state_next = SC_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    case (state)
      SC_IDLE: if (take) begin
        x <= 128'(job.significand) << FRACTION_BITS;
        lim <= job.negative ? LIM_NEG : LIM_POS;
        steps <= (e_in < 0) ? 11'(-e_in) - 11'd1 : 11'(e_in) - 11'd1;
        neg <= job.negative;
        status <= job.status;
        div_chunk <= 2'd3;
        div_rem <= 4'd0;
      end
      SC_UP: if (!(steps == 11'd0 || over)) begin
        x <= x_mul;
        steps <= steps - 11'd1;
      end else if (!over) begin
        x <= x_mul;
      end
      SC_DOWN: if (!down_idle) begin
        x[{div_chunk, 5'd0} +: 32] <= d_q;
        div_chunk <= div_chunk - 2'd1;
        div_rem <= (div_chunk == 2'd0) ? 4'd0 : d_back[3:0];
        if (div_chunk == 2'd0 && steps != 11'd0) steps <= steps - 11'd1;
      end
      default: ;
    endcase
  end

  always_comb begin
    mag_out = x[63:0];
    st_out = status;
    if (over) begin
      mag_out = lim;
      st_out = ST_SAT;
    end
  end

  assign load_direct = (state == SC_IDLE) && take &&
                       !(job.do_scale && job.significand != 64'd0);
  assign load_scaled = (state == SC_DONE) && (!out_ch.valid || out_ch.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= SC_IDLE;
      out_ch.valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load_direct) begin
        out_ch.valid <= 1'b1;
        out_ch.status <= job.status;
        out_ch.value <= job.negative ? -job.magnitude : job.magnitude;
      end else if (load_scaled) begin
        out_ch.valid <= 1'b1;
        out_ch.status <= st_out;
        out_ch.value <= neg ? -mag_out : mag_out;
      end else if (out_ch.valid && out_ch.ready) begin
        out_ch.valid <= 1'b0;
      end
    end
  end

endmodule

>>> design/decimal_text_number_parser_core.sv
// channel | dir | handshake   | payload
// in_ch   | in  | valid/ready | char_code[7:0], last_char
// out_ch  | out | valid/ready | value[63:0] signed, status[1:0]
// cfg     | in  | cfg_we      | cfg_data (number_kind)
// One character is taken each cycle while the queue has room; the last
// character hands the text to the scaling unit through a two-entry queue.
// Scaling up multiplies by ten once per power of ten and stops at the limit;
// scaling down divides by ten, one 32-bit word at a time, once per power of
// ten until the value is zero.
// Reset is synchronous; number_kind returns to real mode.
// Output stall backs up the queue, then the character input.
module decimal_text_number_parser_core
  import dtnp_pkg::*;
#(
  parameter int MAX_DIGITS    = MAX_DIGITS_DEF,
  parameter int FRACTION_BITS = FRACTION_BITS_DEF,
  parameter int EXP_LIMIT     = EXP_LIMIT_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_data,
  dtnp_in_if.sink     in_ch,
  dtnp_out_if.source  out_ch
);

  logic number_kind;
  logic f_valid, f_ready, b_valid, b_ready;
  job_t f_job, b_job;

  always_ff @(posedge clk) begin
    if (rst) number_kind <= 1'b1;
    else if (cfg_we) number_kind <= cfg_data;
  end

  dtnp_front #(.MAX_DIGITS(MAX_DIGITS), .EXP_LIMIT(EXP_LIMIT)) u_front (
    .clk, .rst, .number_kind, .in_ch,
    .job_valid(f_valid), .job(f_job), .job_ready(f_ready)
  );

  dtnp_queue u_queue (
    .clk, .rst,
    .in_valid(f_valid), .in_job(f_job), .in_ready(f_ready),
    .out_valid(b_valid), .out_job(b_job), .out_ready(b_ready)
  );

  dtnp_back #(.FRACTION_BITS(FRACTION_BITS)) u_back (
    .clk, .rst,
    .job_valid(b_valid), .job(b_job), .job_ready(b_ready), .out_ch
  );

endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 100ps

module tb;
  import dtnp_pkg::*;

  localparam int WATCH_LIMIT = 20000;
  localparam int HOLD_CYCLES = 400;

  logic clk;
  logic rst;
  logic cfg_we;
  logic cfg_data;

  dtnp_in_if  in_ch ();
  dtnp_out_if out_ch ();

  decimal_text_number_parser_core u_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .in_ch    (in_ch),
    .out_ch   (out_ch)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // parser copy
  logic        kind;
  phase_t      ph;
  logic        neg;
  logic [63:0] sig;
  int          kept;
  int          dshift;
  logic        eneg;
  int          eval_q;
  logic        seen;
  logic [1:0]  err;
  logic        early;

  logic signed [63:0] want_value[$];
  logic [1:0]         want_status[$];

  int src_idle;
  int snk_idle;
  int mismatches = 0;
  int n_chars;
  int n_texts;
  int n_results = 0;
  int hold_cnt;
  int hold_seq = 0;
  int hold_seen = 0;
  int watch;

  function automatic void clear_text();
    ph = PH_SIGN;
    neg = 1'b0;
    sig = '0;
    kept = 0;
    dshift = 0;
    eneg = 1'b0;
    eval_q = 0;
    seen = 1'b0;
    err = ST_OK;
    early = 1'b0;
  endfunction

  function automatic void shift_point(int d);
    int s;
    s = dshift + d;
    if (s > 511) s = 511;
    if (s < -512) s = -512;
    dshift = s;
  endfunction

  function automatic void take_mant_digit(logic [63:0] d, bit frac);
    seen = 1'b1;
    if (sig == 0 && d == 0) begin
      if (frac) shift_point(-1);
    end else if (kept < MAX_DIGITS_DEF && sig <= 64'h1999_9999_9999_9998) begin
      sig = sig * 10 + d;
      kept++;
      if (frac) shift_point(-1);
    end else if (!frac) begin
      shift_point(1);
    end
  endfunction

  function automatic void take_exp_digit(int d);
    int v;
    v = eval_q * 10 + d;
    eval_q = (v > EXP_LIMIT_DEF) ? EXP_LIMIT_DEF : v;
    ph = PH_EDIG;
  endfunction

  function automatic void parse_char(logic [7:0] c);
    bit          digit;
    bit          is_e;
    logic [63:0] d;
    logic [63:0] lim;
    digit = c >= "0" && c <= "9";
    is_e = c == "e" || c == "E";
    d = {56'd0, c} - 64'd48;
    if (c == 8'd0) begin
      early = 1'b1;
      return;
    end
    if (ph == PH_SIGN) begin
      ph = PH_INT;
      if (c == "+" || c == "-") begin
        neg = c == "-";
        return;
      end
    end
    if (kind == 1'b0) begin
      lim = neg ? LIM_NEG : LIM_POS;
      if (ph != PH_INT || !digit) begin
        err = ST_BAD;
        return;
      end
      seen = 1'b1;
      if (sig > (lim - d) / 10) begin
        sig = lim;
        err = ST_SAT;
      end else begin
        sig = sig * 10 + d;
      end
      return;
    end
    case (ph)
      PH_INT, PH_FRAC: begin
        if (digit) take_mant_digit(d, ph == PH_FRAC);
        else if (ph == PH_INT && (c == "." || c == ",")) ph = PH_FRAC;
        else if (is_e && seen) ph = PH_E;
        else err = ST_BAD;
      end
      PH_E: begin
        if (c == "+" || c == "-") begin
          eneg = c == "-";
          ph = PH_ESIGN;
        end else if (digit) take_exp_digit(int'(d));
        else err = ST_BAD;
      end
      PH_ESIGN, PH_EDIG: begin
        if (digit) take_exp_digit(int'(d));
        else err = ST_BAD;
      end
      default: err = ST_BAD;
    endcase
  endfunction

  function automatic logic [63:0] scale_fixed(logic [63:0] lim, output bit sat);
    logic [127:0] x;
    int           e;
    int           k;
    e = dshift + (eneg ? -eval_q : eval_q);
    x = {64'd0, sig} << FRACTION_BITS_DEF;
    sat = 1'b0;
    if (sig == 0) return '0;
    for (k = 0; k < e && x <= {64'd0, lim}; k++) x = x * 10;
    for (k = 0; k < -e && x != 0; k++) x = x / 10;
    if (x > {64'd0, lim}) begin
      sat = 1'b1;
      return lim;
    end
    return x[63:0];
  endfunction

  function automatic void close_text();
    logic [63:0] lim;
    logic [63:0] mag;
    logic [1:0]  st;
    bit          sat;
    lim = neg ? LIM_NEG : LIM_POS;
    mag = '0;
    sat = 1'b0;
    if (err == ST_BAD) st = ST_BAD;
    else if (ph == PH_SIGN) st = ST_EMPTY;
    else if (!seen) st = ST_BAD;
    else if (kind == 1'b0) begin
      if (ph != PH_INT) st = ST_BAD;
      else begin
        mag = sig;
        if (mag > lim) begin
          mag = lim;
          sat = 1'b1;
        end
        st = (sat || err == ST_SAT) ? ST_SAT : ST_OK;
      end
    end else begin
      if (ph == PH_E || ph == PH_ESIGN) st = ST_BAD;
      else begin
        mag = scale_fixed(lim, sat);
        st = (sat || err == ST_SAT) ? ST_SAT : ST_OK;
      end
    end
    if (st == ST_EMPTY || st == ST_BAD) mag = '0;
    want_value.push_back(neg ? -mag : mag);
    want_status.push_back(st);
    clear_text();
  endfunction

  task automatic send_char(logic [7:0] c, logic last);
    while ($urandom_range(99) < src_idle) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.char_code <= c;
    in_ch.last_char <= last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    n_chars++;
    if (!early && err != ST_BAD) parse_char(c);
    if (last) begin
      n_texts++;
      close_text();
    end
  endtask

  task automatic send_text(string s);
    if (s.len() == 0) send_char(8'd0, 1'b1);
    for (int i = 0; i < s.len(); i++) send_char(s[i], i == s.len() - 1);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (want_value.size() != 0) @(posedge clk);
  endtask

  task automatic write_kind(logic k);
    drain();
    repeat (150) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_data <= k;
    @(posedge clk);
    cfg_we <= 1'b0;
    kind = k;
  endtask

  function automatic string digits(int n);
    string s;
    s = "";
    for (int i = 0; i < n; i++) s = {s, string'(8'($urandom_range(48, 57)))};
    return s;
  endfunction

  function automatic string random_text();
    string s;
    int    r;
    s = "";
    r = $urandom_range(99);
    if (r < 10) begin
      for (int i = 0; i < $urandom_range(1, 6); i++) s = {s, string'(8'($urandom))};
      return s;
    end
    case ($urandom_range(2))
      0: s = "-";
      1: s = "+";
      default: ;
    endcase
    s = {s, digits($urandom_range(99) < 5 ? $urandom_range(19, 30) : $urandom_range(0, 6))};
    if (kind && $urandom_range(1)) begin
      s = {s, $urandom_range(1) ? "." : ","};
      s = {s, digits($urandom_range(0, 5))};
    end
    if (kind && $urandom_range(2) == 0) begin
      s = {s, $urandom_range(1) ? "e" : "E"};
      case ($urandom_range(2))
        0: s = {s, "-"};
        1: s = {s, "+"};
        default: ;
      endcase
      s = {s, digits($urandom_range(0, 3))};
    end
    if (r < 20 && s.len() > 0) s[$urandom_range(s.len() - 1)] = 8'($urandom);
    return s;
  endfunction

  task automatic random_block(int n_items);
    int    target;
    string s;
    target = n_chars + n_items;
    while (n_chars < target) begin
      s = random_text();
      if (s.len() > 0 && $urandom_range(99) < 4) begin
        for (int i = 0; i < s.len(); i++) send_char(s[i], 1'b0);
        send_char(8'd0, 1'b0);
        send_char(8'($urandom_range(48, 57)), 1'b1);
      end else begin
        send_text(s);
      end
    end
  endtask

  task automatic test_real_directed();
    write_kind(1'b1);
    send_text("3.25");
    send_text("-1,5e-3");
    send_text("1E99");
    send_text("1e-99");
    send_text("0000.000015");
    send_text("123456789012345678901234");
    send_text("+1.5e+2");
    send_text("-99999999999999e9");
    send_text("1e");
    send_text("1e+");
    send_text("e5");
    send_text("-.");
    send_text(".");
    send_text("12a3");
    send_text("");
    send_char("7", 1'b0);
    send_char(8'd0, 1'b0);
    send_char("x", 1'b1);
  endtask

  task automatic test_int_directed();
    write_kind(1'b0);
    send_text("9223372036854775807");
    send_text("-9223372036854775808");
    send_text("99999999999999999999");
    send_text("-99999999999999999999");
    send_text("+");
    send_text("-");
    send_text("1.5");
    send_text("0");
    send_char(8'hFF, 1'b0);
    send_char("1", 1'b1);
  endtask

  task automatic test_kind_mid_text();
    send_text("12");
    send_char("3", 1'b0);
    write_kind(1'b1);
    send_text(".5");
    send_char("1", 1'b0);
    send_char(".", 1'b0);
    write_kind(1'b0);
    send_char("5", 1'b1);
  endtask

  task automatic test_random();
    src_idle = 29;
    snk_idle = 83;
    write_kind(1'b1);
    random_block(150);
    write_kind(1'b0);
    random_block(100);
    src_idle = 83;
    snk_idle = 29;
    write_kind(1'b1);
    random_block(150);
    write_kind(1'b0);
    random_block(100);
    src_idle = 0;
    snk_idle = 0;
    write_kind(1'b1);
    random_block(200);
    write_kind(1'b0);
    random_block(80);
  endtask

  task automatic test_backpressure();
    write_kind(1'b1);
    hold_seq++;
    random_block(60);
    drain();
    random_block(20);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
      hold_cnt <= 0;
    end else begin
      if (hold_seq != hold_seen) begin
        hold_cnt <= HOLD_CYCLES;
        hold_seen <= hold_seq;
        out_ch.ready <= 1'b0;
      end else if (hold_cnt > 0) begin
        hold_cnt <= hold_cnt - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= $urandom_range(99) >= snk_idle;
      end
      if (out_ch.valid && out_ch.ready) begin
        n_results++;
        if (want_value.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result value=%0d status=%0d", out_ch.value, out_ch.status);
        end else begin
          if (out_ch.value !== want_value[0] || out_ch.status !== want_status[0]) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected value=%0d status=%0d, got value=%0d status=%0d",
                       want_value[0], want_status[0], out_ch.value, out_ch.status);
          end
          void'(want_value.pop_front());
          void'(want_status.pop_front());
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      watch <= 0;
    end else if (in_ch.valid || want_value.size() != 0) begin
      watch <= watch + 1;
      if (watch >= WATCH_LIMIT) begin
        $display("watchdog expired with %0d results pending", want_value.size());
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_data = 1'b1;
    in_ch.valid = 1'b0;
    in_ch.char_code = '0;
    in_ch.last_char = 1'b0;
    kind = 1'b1;
    src_idle = 0;
    snk_idle = 0;
    n_chars = 0;
    n_texts = 0;
    clear_text();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_real_directed();
    test_int_directed();
    test_kind_mid_text();
    test_random();
    test_backpressure();
    drain();
    repeat (200) @(posedge clk);
    $display("covered %0d characters in %0d texts, %0d results checked", n_chars, n_texts,
             n_results);
    $display("both number kinds, saturation, bad format, early end and output stalls");
    if (mismatches == 0 && want_value.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatches, want_value.size());
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

>>> sim.f
design/dtnp_pkg.sv
design/dtnp_if.sv
design/dtnp_front.sv
design/dtnp_queue.sv
design/dtnp_back.sv
design/decimal_text_number_parser_core.sv
tb/sv/tb.sv
